### rtl/cit_pkg.sv
// ----------------------------------------------------------------------------
// cit_pkg
// shared types, register map and helpers for the three-criteria choquet
// integral pipeline
// ----------------------------------------------------------------------------
package cit_pkg;

    localparam int unsigned QW     = 16;
    localparam int unsigned QSHIFT = 15;
    localparam int unsigned NREGS  = 7;
    localparam int unsigned PROD_W = 2 * QW;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef logic [QW-1:0]     q15_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [2:0]        crit_mask_t;
    typedef logic [1:0]        crit_idx_t;
    typedef logic [2:0]        reg_idx_t;

    typedef q15_t [NREGS-1:0] measure_set_t;

    typedef enum logic [2:0] {
        REG_MEASURE_CPU              = 3'd0,
        REG_MEASURE_BANDWIDTH        = 3'd1,
        REG_MEASURE_ENERGY           = 3'd2,
        REG_MEASURE_CPU_BANDWIDTH    = 3'd3,
        REG_MEASURE_CPU_ENERGY       = 3'd4,
        REG_MEASURE_BANDWIDTH_ENERGY = 3'd5,
        REG_MEASURE_ALL_THREE        = 3'd6
    } reg_sel_t;

    localparam crit_idx_t IDX_CPU       = 2'd0;
    localparam crit_idx_t IDX_BANDWIDTH = 2'd1;
    localparam crit_idx_t IDX_ENERGY    = 2'd2;

    localparam crit_mask_t MASK_CPU              = 3'b001;
    localparam crit_mask_t MASK_BANDWIDTH        = 3'b010;
    localparam crit_mask_t MASK_ENERGY           = 3'b100;
    localparam crit_mask_t MASK_CPU_BANDWIDTH    = 3'b011;
    localparam crit_mask_t MASK_CPU_ENERGY       = 3'b101;
    localparam crit_mask_t MASK_BANDWIDTH_ENERGY = 3'b110;
    localparam crit_mask_t MASK_ALL_THREE        = 3'b111;

    localparam q15_t RST_MEASURE_CPU              = 16'd9830;
    localparam q15_t RST_MEASURE_BANDWIDTH        = 16'd8192;
    localparam q15_t RST_MEASURE_ENERGY           = 16'd6554;
    localparam q15_t RST_MEASURE_CPU_BANDWIDTH    = 16'd21299;
    localparam q15_t RST_MEASURE_CPU_ENERGY       = 16'd19661;
    localparam q15_t RST_MEASURE_BANDWIDTH_ENERGY = 16'd18022;
    localparam q15_t RST_MEASURE_ALL_THREE        = 16'd32768;

    // sorted differences and their measures
    typedef struct packed {
        q15_t diff0;
        q15_t diff1;
        q15_t diff2;
        q15_t meas0;
        q15_t meas1;
        q15_t meas2;
    } sort_data_t;

    typedef struct packed {
        prod_t prod0;
        prod_t prod1;
        prod_t prod2;
    } prod_data_t;

    function automatic crit_mask_t idx_to_mask(input crit_idx_t idx);
        crit_mask_t m;
        unique case (idx)
            IDX_CPU:       m = MASK_CPU;
            IDX_BANDWIDTH: m = MASK_BANDWIDTH;
            IDX_ENERGY:    m = MASK_ENERGY;
            default:       m = '0;
        endcase
        return m;
    endfunction

    function automatic q15_t measure_for_mask(input measure_set_t ms, input crit_mask_t mask);
        q15_t r;
        unique case (mask)
            MASK_CPU:              r = ms[REG_MEASURE_CPU];
            MASK_BANDWIDTH:        r = ms[REG_MEASURE_BANDWIDTH];
            MASK_ENERGY:           r = ms[REG_MEASURE_ENERGY];
            MASK_CPU_BANDWIDTH:    r = ms[REG_MEASURE_CPU_BANDWIDTH];
            MASK_CPU_ENERGY:       r = ms[REG_MEASURE_CPU_ENERGY];
            MASK_BANDWIDTH_ENERGY: r = ms[REG_MEASURE_BANDWIDTH_ENERGY];
            MASK_ALL_THREE:        r = ms[REG_MEASURE_ALL_THREE];
            default:               r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/cit_in_if.sv
// ----------------------------------------------------------------------------
// cit_in_if
// request channel carrying the three criterion scores
// ----------------------------------------------------------------------------
interface cit_in_if
    import cit_pkg::*;
();
    logic valid;
    logic ready;
    q15_t cpu_score;
    q15_t bandwidth_score;
    q15_t energy_score;

    modport source (output valid, output cpu_score, output bandwidth_score,
                    output energy_score, input ready);
    modport sink   (input valid, input cpu_score, input bandwidth_score,
                    input energy_score, output ready);
endinterface

### rtl/cit_out_if.sv
// ----------------------------------------------------------------------------
// cit_out_if
// result channel carrying the aggregate score
// ----------------------------------------------------------------------------
interface cit_out_if
    import cit_pkg::*;
();
    logic valid;
    logic ready;
    q15_t aggregate;

    modport source (output valid, output aggregate, input ready);
    modport sink   (input valid, input aggregate, output ready);
endinterface

### rtl/choquet_integral_three_criteria.sv
// ----------------------------------------------------------------------------
// choquet_integral_three_criteria
// discrete choquet integral of three q1.15 scores with programmable measures
//
//  channel   dir  handshake        payload
//  in_chan   in   valid / ready    cpu_score, bandwidth_score, energy_score
//  out_chan  out  valid / ready    aggregate
//  apb       in   psel / penable   paddr, pwdata, prdata (7 measures, 4-byte)
//
// one request per cycle sustained while out_chan is ready; a request passes, in order, through the
// sort stage, multiply stage and sum stage (which is the output register)
// reset loads the default measures and empties the pipeline
// a stall freezes each full stage; an empty stage keeps accepting
// ----------------------------------------------------------------------------
module choquet_integral_three_criteria
    import cit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    cit_in_if.sink            in_chan,
    cit_out_if.source         out_chan,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    measure_set_t measures;
    sort_data_t   s1_data;
    prod_data_t   s2_data;
    logic         s1_valid, s1_ready;
    logic         s2_valid, s2_ready;

    cit_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .measures (measures)
    );

    cit_sort_stage u_sort (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_chan.valid),
        .in_ready        (in_chan.ready),
        .cpu_score       (in_chan.cpu_score),
        .bandwidth_score (in_chan.bandwidth_score),
        .energy_score    (in_chan.energy_score),
        .measures        (measures),
        .out_valid       (s1_valid),
        .out_ready       (s1_ready),
        .out_data        (s1_data)
    );

    cit_mult_stage u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    cit_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .aggregate (out_chan.aggregate)
    );

endmodule

### rtl/cit_regs.sv
// ----------------------------------------------------------------------------
// cit_regs
// apb register file holding the seven subset measures
// ----------------------------------------------------------------------------
module cit_regs
    import cit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output measure_set_t      measures
);

    measure_set_t measure_reg;
    reg_idx_t     idx;
    logic         wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (idx <= REG_MEASURE_ALL_THREE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measure_reg[REG_MEASURE_CPU]              <= RST_MEASURE_CPU;
            measure_reg[REG_MEASURE_BANDWIDTH]        <= RST_MEASURE_BANDWIDTH;
            measure_reg[REG_MEASURE_ENERGY]           <= RST_MEASURE_ENERGY;
            measure_reg[REG_MEASURE_CPU_BANDWIDTH]    <= RST_MEASURE_CPU_BANDWIDTH;
            measure_reg[REG_MEASURE_CPU_ENERGY]       <= RST_MEASURE_CPU_ENERGY;
            measure_reg[REG_MEASURE_BANDWIDTH_ENERGY] <= RST_MEASURE_BANDWIDTH_ENERGY;
            measure_reg[REG_MEASURE_ALL_THREE]        <= RST_MEASURE_ALL_THREE;
        end
        else if (wr_en)
        begin
            measure_reg[idx] <= pwdata[QW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx <= REG_MEASURE_ALL_THREE)
        begin
            prdata = {{(DATA_W-QW){1'b0}}, measure_reg[idx]};
        end
    end

    assign measures = measure_reg;

endmodule

### rtl/cit_sort_stage.sv
// ----------------------------------------------------------------------------
// cit_sort_stage
// first stage: descending sort, nested subset masks, differences and measures
// ----------------------------------------------------------------------------
module cit_sort_stage
    import cit_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  q15_t         cpu_score,
    input  q15_t         bandwidth_score,
    input  q15_t         energy_score,
    input  measure_set_t measures,
    output logic         out_valid,
    input  logic         out_ready,
    output sort_data_t   out_data
);

    logic       valid_reg;
    sort_data_t data_reg;
    sort_data_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        q15_t       v0, v1, v2, tv;
        crit_idx_t  o0, o1, o2, ti;
        crit_mask_t mask1, mask2;
        tv = '0;
        ti = IDX_CPU;
        v0 = cpu_score;       o0 = IDX_CPU;
        v1 = bandwidth_score; o1 = IDX_BANDWIDTH;
        v2 = energy_score;    o2 = IDX_ENERGY;
        if (v1 > v0)
        begin
            tv = v0; v0 = v1; v1 = tv;
            ti = o0; o0 = o1; o1 = ti;
        end
        if (v2 > v0)
        begin
            tv = v0; v0 = v2; v2 = tv;
            ti = o0; o0 = o2; o2 = ti;
        end
        if (v2 > v1)
        begin
            tv = v1; v1 = v2; v2 = tv;
            ti = o1; o1 = o2; o2 = ti;
        end
        mask1 = idx_to_mask(o0);
        mask2 = mask1 | idx_to_mask(o1);
        data_next.diff0 = v0 - v1;
        data_next.diff1 = v1 - v2;
        data_next.diff2 = v2;
        data_next.meas0 = measure_for_mask(measures, mask1);
        data_next.meas1 = measure_for_mask(measures, mask2);
        data_next.meas2 = measure_for_mask(measures, MASK_ALL_THREE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/cit_mult_stage.sv
// ----------------------------------------------------------------------------
// cit_mult_stage
// second stage: three 16x16 products of difference and measure
// ----------------------------------------------------------------------------
module cit_mult_stage
    import cit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sort_data_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output prod_data_t out_data
);

    logic       valid_reg;
    prod_data_t data_reg;
    prod_data_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.prod0 = PROD_W'(in_data.diff0) * PROD_W'(in_data.meas0);
        data_next.prod1 = PROD_W'(in_data.diff1) * PROD_W'(in_data.meas1);
        data_next.prod2 = PROD_W'(in_data.diff2) * PROD_W'(in_data.meas2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/cit_sum_stage.sv
// ----------------------------------------------------------------------------
// cit_sum_stage
// third stage: exact sum, shift by fifteen, saturate; doubles as output register
// ----------------------------------------------------------------------------
module cit_sum_stage
    import cit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  prod_data_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output q15_t       aggregate
);

    logic             valid_reg;
    q15_t             agg_reg;
    q15_t             agg_next;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-QSHIFT-1:0] shifted;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sum = SUM_W'(in_data.prod0) + SUM_W'(in_data.prod1) + SUM_W'(in_data.prod2);
        shifted = sum[SUM_W-1:QSHIFT];
        if (|shifted[SUM_W-QSHIFT-1:QW])
        begin
            agg_next = '1;
        end
        else
        begin
            agg_next = shifted[QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            agg_reg <= agg_next;
        end
    end

    assign out_valid = valid_reg;
    assign aggregate = agg_reg;

endmodule

### tb/choquet_integral_three_criteria_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// choquet_integral_three_criteria_tb
// self-checking bench for the three-criteria choquet integral pipeline
// a queue-fed driver offers score requests and a clocked monitor checks each
// aggregate against a local predictor in request order
// measures reprogrammed over apb between phases: zero, unity, 16-bit maximum
// and random values; both channels idle at random, one long result hold-off
// ----------------------------------------------------------------------------
module choquet_integral_three_criteria_tb
    import cit_pkg::*;
;

    localparam int unsigned PIPE_LATENCY    = 3;
    localparam int unsigned NUM_PHASES      = 7;
    localparam int unsigned ITEMS_PER_PHASE = 130;
    localparam int unsigned HOLDOFF_PHASE   = 5;
    localparam int unsigned HOLDOFF_CYCLES  = 64;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam q15_t        Q_ONE           = 16'd32768;
    localparam q15_t        AGG_MAX         = '1;
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(NREGS * 4);

    typedef struct packed {
        q15_t cpu;
        q15_t bandwidth;
        q15_t energy;
    } score_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cit_in_if  in_chan ();
    cit_out_if out_chan ();

    choquet_integral_three_criteria u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // subset measures indexed by criterion mask
    q15_t       subset_measure [8];
    crit_mask_t reg_mask_of [NREGS] = '{MASK_CPU, MASK_BANDWIDTH, MASK_ENERGY,
                                        MASK_CPU_BANDWIDTH, MASK_CPU_ENERGY,
                                        MASK_BANDWIDTH_ENERGY, MASK_ALL_THREE};
    q15_t       reset_measure [NREGS] = '{RST_MEASURE_CPU, RST_MEASURE_BANDWIDTH,
                                          RST_MEASURE_ENERGY, RST_MEASURE_CPU_BANDWIDTH,
                                          RST_MEASURE_CPU_ENERGY,
                                          RST_MEASURE_BANDWIDTH_ENERGY,
                                          RST_MEASURE_ALL_THREE};

    score_req_t  pending_req [$];
    q15_t        expected_aggregate [$];
    score_req_t  staged_req;
    score_req_t  accepted_req;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        holdoff_armed = 1'b0;
    logic        sink_hold     = 1'b0;
    int unsigned stall_cycles  = 0;
    int unsigned n_queued      = 0;
    int unsigned n_requests    = 0;
    int unsigned n_results     = 0;
    int unsigned n_settings    = 0;
    int unsigned mismatches    = 0;

    function automatic q15_t choquet_aggregate(input score_req_t r);
        q15_t             score [3];
        int unsigned      rank [3];
        int unsigned      t;
        crit_mask_t       taken;
        q15_t             nxt;
        logic [SUM_W-1:0] acc;
        logic [SUM_W-1:0] shifted;
        score[IDX_CPU]       = r.cpu;
        score[IDX_BANDWIDTH] = r.bandwidth;
        score[IDX_ENERGY]    = r.energy;
        rank = '{0, 1, 2};
        for (int i = 0; i < 2; i++)
        begin
            for (int j = i + 1; j < 3; j++)
            begin
                if (score[rank[j]] > score[rank[i]])
                begin
                    t       = rank[i];
                    rank[i] = rank[j];
                    rank[j] = t;
                end
            end
        end
        taken = '0;
        acc   = '0;
        for (int k = 0; k < 3; k++)
        begin
            taken = taken | crit_mask_t'(1 << rank[k]);
            nxt   = (k < 2) ? score[rank[k + 1]] : '0;
            acc   = acc + SUM_W'(q15_t'(score[rank[k]] - nxt))
                        * SUM_W'(subset_measure[taken]);
        end
        shifted = acc >> QSHIFT;
        return (shifted > SUM_W'(AGG_MAX)) ? AGG_MAX : q15_t'(shifted);
    endfunction

    function automatic q15_t random_score();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q_ONE;
            2:       return q15_t'($urandom_range(0, 65535));
            3:       return q15_t'($urandom_range(0, 64));
            default: return q15_t'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic score_req_t random_request();
        score_req_t r;
        r.cpu       = random_score();
        r.bandwidth = random_score();
        r.energy    = random_score();
        case ($urandom_range(0, 7))
            0: r.bandwidth = r.cpu;
            1: r.energy = r.bandwidth;
            2: r.cpu = r.energy;
            3:
            begin
                r.bandwidth = r.cpu;
                r.energy    = r.cpu;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic enqueue_request(input score_req_t r);
        pending_req = {pending_req, r};
        n_queued++;
    endtask

    task automatic offer(input q15_t c, input q15_t b, input q15_t e);
        enqueue_request(score_req_t'({c, b, e}));
    endtask

    task automatic queue_directed();
        offer(16'd0, 16'd0, 16'd0);
        offer(Q_ONE, Q_ONE, Q_ONE);
        offer(Q_ONE, 16'd0, 16'd0);
        offer(16'd0, Q_ONE, 16'd0);
        offer(16'd0, 16'd0, Q_ONE);
        offer(Q_ONE, Q_ONE, 16'd0);
        offer(Q_ONE, 16'd0, Q_ONE);
        offer(16'd0, Q_ONE, Q_ONE);
        offer(16'd30000, 16'd20000, 16'd10000);
        offer(16'd30000, 16'd10000, 16'd20000);
        offer(16'd20000, 16'd30000, 16'd10000);
        offer(16'd10000, 16'd30000, 16'd20000);
        offer(16'd20000, 16'd10000, 16'd30000);
        offer(16'd10000, 16'd20000, 16'd30000);
        offer(16'd20000, 16'd20000, 16'd5000);
        offer(16'd5000, 16'd20000, 16'd20000);
        offer(16'd20000, 16'd5000, 16'd20000);
        offer(16'd1, 16'd0, 16'd0);
        offer(16'hAAAA, 16'h5555, 16'h8001);
    endtask

    // full-range extremes, saturating once the measures exceed one
    task automatic queue_extremes();
        offer(AGG_MAX, AGG_MAX, AGG_MAX);
        offer(AGG_MAX, 16'd0, 16'd0);
        offer(Q_ONE, Q_ONE, Q_ONE);
        offer(16'd0, 16'd0, 16'd0);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((addr >> 2) < NREGS)
            subset_measure[reg_mask_of[addr >> 2]] = data[QW-1:0];
    endtask

    task automatic program_measures(input q15_t m [NREGS]);
        for (int k = 0; k < NREGS; k++)
            apb_write(ADDR_W'(k * 4), {16'($urandom()), m[k]});
        apb_write(UNMAPPED_ADDR, $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_idle();
        while (n_results < n_queued || expected_aggregate.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chan.valid           <= 1'b0;
            in_chan.cpu_score       <= '0;
            in_chan.bandwidth_score <= '0;
            in_chan.energy_score    <= '0;
        end
        else
        begin
            if (in_chan.valid && in_chan.ready)
            begin
                accepted_req = {in_chan.cpu_score, in_chan.bandwidth_score,
                                in_chan.energy_score};
                expected_aggregate = {expected_aggregate, choquet_aggregate(accepted_req)};
                n_requests++;
            end
            if (!in_chan.valid || in_chan.ready)
            begin
                if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    staged_req = pending_req.pop_front();
                    in_chan.valid           <= 1'b1;
                    in_chan.cpu_score       <= staged_req.cpu;
                    in_chan.bandwidth_score <= staged_req.bandwidth;
                    in_chan.energy_score    <= staged_req.energy;
                end
                else
                begin
                    in_chan.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_chan.ready <= 1'b0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                n_results++;
                if (expected_aggregate.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: aggregate %0d", out_chan.aggregate);
                    mismatches++;
                end
                else if (out_chan.aggregate !== expected_aggregate[0])
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("aggregate mismatch: expected %0d, got %0d",
                                 expected_aggregate[0], out_chan.aggregate);
                    mismatches++;
                    void'(expected_aggregate.pop_front());
                end
                else
                begin
                    void'(expected_aggregate.pop_front());
                end
            end
            out_chan.ready <= !sink_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin : sink_holdoff
        wait (holdoff_armed);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
            || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("** choquet_integral_three_criteria: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        q15_t m [NREGS];
        subset_measure[0] = '0;
        for (int k = 0; k < NREGS; k++)
            subset_measure[reg_mask_of[k]] = reset_measure[k];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                for (int k = 0; k < NREGS; k++)
                begin
                    case (ph)
                        1:       m[k] = '0;
                        2:       m[k] = Q_ONE;
                        3:       m[k] = AGG_MAX;
                        4:       m[k] = q15_t'($urandom_range(0, 32768));
                        5:       m[k] = q15_t'($urandom());
                        default: m[k] = q15_t'($urandom_range(0, 16384));
                    endcase
                end
                if (ph == 6)
                begin
                    m[REG_MEASURE_CPU_BANDWIDTH]    = q15_t'($urandom_range(16384, 32768));
                    m[REG_MEASURE_CPU_ENERGY]       = q15_t'($urandom_range(16384, 32768));
                    m[REG_MEASURE_BANDWIDTH_ENERGY] = q15_t'($urandom_range(16384, 32768));
                    m[REG_MEASURE_ALL_THREE]        = Q_ONE;
                end
                program_measures(m);
            end
            if (ph < 2)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 78;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0)
                queue_directed();
            queue_extremes();
            if (ph == HOLDOFF_PHASE)
                holdoff_armed = 1'b1;
            repeat (ITEMS_PER_PHASE) enqueue_request(random_request());
            wait_idle();
        end
        if (expected_aggregate.size() != 0)
            $display("%0d expected results never arrived", expected_aggregate.size());
        mismatches += expected_aggregate.size();
        $display("ran %0d requests and %0d results over %0d measure settings plus reset",
                 n_requests, n_results, n_settings);
        $display("sender and receiver idling swapped, one long result hold-off, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("** choquet_integral_three_criteria: PASSED **");
        else
            $display("** choquet_integral_three_criteria: FAILED **");
        $finish;
    end

endmodule
